// File: src/mesh_network_id_selector_top_defines.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef MESH_NETWORK_ID_SELECTOR_TOP_DEFINES_SVH
`define MESH_NETWORK_ID_SELECTOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NIS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("check failed");
`define NIS_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error("check failed");
`else
`define NIS_ASSERT_ALWAYS(lbl, expr)
`define NIS_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

// File: src/nis_pkg.sv
`default_nettype none
package nis_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_AGE = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;
  localparam logic [1:0] OP_DECR = 2'd3;

  localparam logic [2:0] REG_MASTER_ID = 3'd0;
  localparam logic [2:0] REG_PREFERRED_ID = 3'd1;
  localparam logic [2:0] REG_MIN_COUNT = 3'd2;
  localparam logic [2:0] REG_MAX_COUNT = 3'd3;
  localparam logic [2:0] REG_AGE_TIMEOUT = 3'd4;

  localparam logic [7:0] MASTER_TTL = 8'd255;
  localparam logic [3:0] MASTER_RATE_RELOAD = 4'd10;
  localparam logic [31:0] LAST_SEEN_FLOOR = 32'd5000;
  localparam logic [31:0] LAST_SEEN_STEP = 32'd1000;

  typedef struct packed {
    logic [15:0] master_id;
    logic [15:0] preferred_id;
    logic [5:0]  min_count;
    logic [5:0]  max_count;
    logic [15:0] age_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] net_id;
    logic [7:0]  net_ttl;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  ttl;
    logic        dropped;
  } res_t;

  typedef struct packed {
    logic [15:0] ident;
    logic [7:0]  life;
    logic [5:0]  sightings;
    logic [31:0] last_seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: src/nis_ram.sv
`default_nettype none
module nis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/nis_core.sv
`default_nettype none
`include "mesh_network_id_selector_top_defines.svh"
module nis_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire nis_pkg::cfg_t cfg,
  input  wire logic item_valid,
  input  wire nis_pkg::item_t item,
  output logic busy,
  output logic res_valid,
  input  wire logic res_take,
  output nis_pkg::res_t res
);
  import nis_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic job_obs, job_age, job_sel;
  logic [15:0] obs_id;
  logic [7:0] obs_ttl;
  logic [31:0] now_q;
  logic [FILL_W-1:0] fill_count, rd_idx;
  logic [IDX_W-1:0] ev_idx;
  logic ev_valid;
  logic [3:0] master_rate;
  logic [5:0] best_cnt;
  logic [15:0] best_id;
  logic [7:0] best_ttl;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t ram_wdata, ev;
  logic [ENTRY_W-1:0] ram_rdata;

  logic accept, scan_more, match, live, pref_hit, scan_end, table_full, aged;
  logic master_sel, master_readd;
  entry_t upd, aged_e, fresh;
  res_t start_res;

  assign accept = item_valid && (state == ST_IDLE);
  assign busy = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign ev = entry_t'(ram_rdata);
  assign scan_more = rd_idx < fill_count;
  assign table_full = fill_count >= FILL_W'(ENTRIES);
  assign match = ev_valid && (ev.ident == obs_id);
  assign live = (ev.life != 8'd0) && (ev.sightings >= cfg.min_count);
  assign pref_hit = ev_valid && live && (ev.ident == cfg.preferred_id);
  assign scan_end = !ev_valid && !scan_more;
  assign aged = ({1'b0, ev.last_seen} + {17'b0, cfg.age_timeout_ms}) < {1'b0, now_q};
  assign master_sel = (item.operation == OP_SELECT) && (cfg.master_id != 16'd0);
  assign master_readd = master_sel && (master_rate == 4'd0);

  always_comb begin
    start_res = '0;
    case (item.operation)
      OP_SELECT: begin
        if (master_sel) begin
          start_res.id = cfg.master_id;
          start_res.ttl = MASTER_TTL;
        end
      end
      OP_DECR: begin
        start_res.id = item.net_id;
        if (cfg.master_id != 16'd0) begin
          start_res.ttl = MASTER_TTL;
        end else if (item.net_ttl != 8'd0) begin
          start_res.ttl = item.net_ttl - 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    upd = ev;
    if (ev.sightings < cfg.max_count) begin
      upd.sightings = ev.sightings + 6'd1;
    end
    if (obs_ttl < ev.life) begin
      upd.life = ev.life - 8'd1;
      if (ev.last_seen > LAST_SEEN_FLOOR) begin
        upd.last_seen = ev.last_seen - LAST_SEEN_STEP;
      end
    end else begin
      upd.life = obs_ttl;
      upd.last_seen = now_q;
    end

    aged_e = ev;
    if (ev.sightings != 6'd0) begin
      if (aged) begin
        aged_e.sightings = ev.sightings - 6'd1;
      end
    end else begin
      aged_e.life = 8'd0;
    end

    fresh.ident = obs_id;
    fresh.life = obs_ttl;
    fresh.sightings = 6'd1;
    fresh.last_seen = now_q;

    ram_we = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = ev;
    if (state == ST_SCAN) begin
      if (job_obs && match) begin
        ram_we = 1'b1;
        ram_wdata = upd;
      end else if (job_age && ev_valid) begin
        ram_we = 1'b1;
        ram_wdata = aged_e;
      end else if (job_obs && scan_end && !table_full) begin
        ram_we = 1'b1;
        ram_waddr = fill_count[IDX_W-1:0];
        ram_wdata = fresh;
      end
    end
  end

  nis_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill_count <= '0;
      master_rate <= '0;
      ev_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            job_obs <= (item.operation == OP_OBSERVE) || master_readd;
            job_age <= (item.operation == OP_AGE);
            job_sel <= (item.operation == OP_SELECT) && !master_sel;
            obs_id <= master_readd ? cfg.master_id : item.net_id;
            obs_ttl <= master_readd ? MASTER_TTL : item.net_ttl;
            now_q <= item.now_ms;
            rd_idx <= '0;
            ev_valid <= 1'b0;
            best_cnt <= '0;
            best_id <= '0;
            best_ttl <= '0;
            res <= start_res;
            if (master_sel) begin
              master_rate <= master_readd ? (MASTER_RATE_RELOAD - 4'd1) : (master_rate - 4'd1);
            end
            if ((item.operation == OP_DECR) || (master_sel && !master_readd)) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // reads run one entry ahead of evaluation
          ev_valid <= scan_more;
          ev_idx <= rd_idx[IDX_W-1:0];
          if (scan_more) begin
            rd_idx <= rd_idx + FILL_W'(1);
          end
          if (job_sel && ev_valid && live && ev.sightings > best_cnt) begin
            best_cnt <= ev.sightings;
            best_id <= ev.ident;
            best_ttl <= ev.life;
          end
          if (job_obs && match) begin
            state <= ST_DONE;
          end else if (job_sel && pref_hit) begin
            res <= '{id: ev.ident, ttl: ev.life, dropped: 1'b0};
            state <= ST_DONE;
          end else if (scan_end) begin
            state <= ST_DONE;
            if (job_sel) begin
              res <= '{id: best_id, ttl: best_ttl, dropped: 1'b0};
            end else if (job_obs && table_full) begin
              res.dropped <= 1'b1;
            end
            if (job_obs && !table_full) begin
              fill_count <= fill_count + FILL_W'(1);
            end
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `NIS_ASSERT_ALWAYS(a_fill_bound, fill_count <= FILL_W'(ENTRIES))
  `NIS_ASSERT_ALWAYS(a_write_in_scan, !ram_we || state == ST_SCAN)
  `NIS_ASSERT_ALWAYS(a_rate_bound, master_rate < MASTER_RATE_RELOAD)
  `NIS_ASSERT_NEXT(a_accept_busy, accept, state != ST_IDLE)
  `NIS_ASSERT_NEXT(a_fill_step, state == ST_IDLE, fill_count == $past(fill_count))
endmodule
`default_nettype wire

// File: src/mesh_network_id_selector_top.sv
// Observe, age tick and auto select load the output register after a table scan that reads
// one entry per cycle, through the core's scan and done states; a matching observe or a
// preferred hit ends the scan early. Decrement and master select without re-add skip the
// scan and go from idle to the done state before loading it.
// Throughput: one transaction in flight; a new input is accepted in the cycle after the result
// moves to the output register. Reset restores config defaults, fill count and master rate.
`default_nettype none
module mesh_network_id_selector_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [15:0] net_id,
  input  wire logic [7:0] net_ttl,
  input  wire logic [31:0] now_ms,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [15:0] result_id,
  output logic [7:0] result_ttl,
  output logic insert_dropped,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  import nis_pkg::*;

  cfg_t cfg;
  item_t item;
  res_t res;
  logic busy, res_valid, res_take;

  assign cfg_ready = 1'b1;
  assign in_stall = busy;
  assign item = '{operation: operation, net_id: net_id, net_ttl: net_ttl, now_ms: now_ms};
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master_id <= 16'd0;
      cfg.preferred_id <= 16'd0;
      cfg.min_count <= 6'd10;
      cfg.max_count <= 6'd50;
      cfg.age_timeout_ms <= 16'd15000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MASTER_ID: cfg.master_id <= cfg_data;
        REG_PREFERRED_ID: cfg.preferred_id <= cfg_data;
        REG_MIN_COUNT: cfg.min_count <= cfg_data[5:0];
        REG_MAX_COUNT: cfg.max_count <= cfg_data[5:0];
        REG_AGE_TIMEOUT: cfg.age_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  nis_core u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .item_valid(in_valid),
    .item(item),
    .busy(busy),
    .res_valid(res_valid),
    .res_take(res_take),
    .res(res)
  );

  // hold the result until the downstream side takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result_id <= res.id;
      result_ttl <= res.ttl;
      insert_dropped <= res.dropped;
    end
  end
endmodule
`default_nettype wire
